// ===== rtl/core/ppm_pkg.sv =====
`default_nettype none
package ppm_pkg;

  localparam int PORTS = 8;
  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;

  localparam int DIVW = 58;
  localparam int DCW = $clog2(DIVW + 1);

  localparam logic [2:0] MODE_RECV  = 3'd0;
  localparam logic [2:0] MODE_PROC  = 3'd1;
  localparam logic [2:0] MODE_BYTES = 3'd2;
  localparam logic [2:0] MODE_LAT   = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;
  localparam logic [2:0] MODE_CHECK = 3'd5;
  localparam logic [2:0] MODE_CLEAR = 3'd6;
  localparam logic [2:0] MODE_NONE  = 3'd7;

  localparam logic [1:0] REG_LAT_LIMIT  = 2'd0;
  localparam logic [1:0] REG_TPUT_LIMIT = 2'd1;
  localparam logic [1:0] REG_ERR_LIMIT  = 2'd2;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef logic [PIW-1:0] idx_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  port;
    logic        success;
    logic [31:0] data_bytes;
    logic [31:0] latency_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  port_id;
    logic        latency_alert;
    logic        throughput_alert;
    logic        error_alert;
    logic [31:0] peak_latency;
    logic [31:0] least_latency;
    logic [47:0] rate_bytes_per_s;
    logic [31:0] failed_tasks;
    logic [31:0] processed_tasks;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic clr_idx;
    logic inc_idx;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_check;
    logic active;
    logic idx_end;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/ppm_ctrl.sv =====
`default_nettype none
module ppm_ctrl
  import ppm_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [DCW-1:0] cnt;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.clr_idx = 1'b1;
        state_next = sts.is_check ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.active) begin
          cmd.div_load = 1'b1;
          state_next = ST_DIV;
        end else if (sts.idx_end) begin
          state_next = ST_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DCW'(DIVW - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          if (sts.idx_end) begin
            state_next = ST_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.div_load) cnt <= '0;
      else if (cmd.div_step) cnt <= cnt + DCW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ppm_dp.sv =====
`default_nettype none
module ppm_dp
  import ppm_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  in_item_t         in_item,
  input  wire              cfg_we,
  input  wire [1:0]        cfg_index,
  input  wire [31:0]       cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  wire              out_stall,
  output out_item_t        out_item
);

  logic [31:0] recv_cnt [PORTS];
  logic [31:0] proc_cnt [PORTS];
  logic [31:0] succ_cnt [PORTS];
  logic [47:0] byte_tot [PORTS];
  logic [31:0] max_lat  [PORTS];
  logic [31:0] min_lat  [PORTS];
  logic [PORTS-1:0] active;
  logic [39:0] elapsed;

  logic [31:0] lat_limit;
  logic [31:0] tput_limit;
  logic [6:0]  err_limit;

  in_item_t item;
  idx_t     idx;
  idx_t     addr;
  logic     port_ok;

  logic [DIVW-1:0] quo;
  logic [40:0]     rem;
  logic [40:0]     rem_sh;
  logic [40:0]     rem_sub;

  logic [31:0] r_proc;
  logic [31:0] r_failed;
  logic [31:0] r_max;
  logic [47:0] r_bytes;
  logic [57:0] prod;
  logic [38:0] fail_x100;
  logic [38:0] lim_x_proc;
  logic [48:0] byte_sum;
  logic [47:0] rate;
  logic        last_cur;

  assign port_ok = (7'(item.port) < 7'(PORTS));
  assign addr = cmd.exec ? idx_t'(item.port) : idx;

  assign r_proc   = proc_cnt[addr];
  assign r_max    = max_lat[addr];
  assign r_bytes  = byte_tot[addr];
  assign r_failed = r_proc - succ_cnt[addr];

  // bytes * 1000 as shifts
  assign prod = (58'(r_bytes) << 10) - (58'(r_bytes) << 4) - (58'(r_bytes) << 3);
  assign fail_x100 = (39'(r_failed) << 6) + (39'(r_failed) << 5) + (39'(r_failed) << 2);
  assign lim_x_proc = 39'(err_limit) * 39'(r_proc);
  assign byte_sum = 49'(r_bytes) + 49'(item.data_bytes);

  assign rem_sh  = {rem[39:0], quo[DIVW-1]};
  assign rem_sub = rem_sh - {1'b0, elapsed};

  always_comb begin
    if (elapsed == '0) rate = '0;
    else if (|quo[DIVW-1:48]) rate = MAX48;
    else rate = quo[47:0];
  end

  always_comb begin
    last_cur = 1'b1;
    for (int j = 0; j < PORTS; j++) begin
      if (j > int'(idx) && active[j]) last_cur = 1'b0;
    end
  end

  assign sts.is_check = (item.mode == MODE_CHECK);
  assign sts.active   = active[idx];
  assign sts.idx_end  = (idx == idx_t'(PORTS - 1));
  assign sts.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_limit <= 32'd1000;
      tput_limit <= '0;
      err_limit <= 7'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAT_LIMIT:  lat_limit <= cfg_data;
        REG_TPUT_LIMIT: tput_limit <= cfg_data;
        REG_ERR_LIMIT:  err_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
    if (cmd.clr_idx) idx <= '0;
    else if (cmd.inc_idx) idx <= idx + idx_t'(1);
    if (cmd.div_load) begin
      quo <= prod;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[40]) begin
        rem <= rem_sub;
        quo <= {quo[DIVW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIVW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_item.port_id <= 3'(idx);
      out_item.latency_alert <= (r_max > lat_limit);
      out_item.throughput_alert <= (rate < 48'(tput_limit));
      out_item.error_alert <= (fail_x100 > lim_x_proc);
      out_item.peak_latency <= r_max;
      out_item.least_latency <= min_lat[addr];
      out_item.rate_bytes_per_s <= rate;
      out_item.failed_tasks <= r_failed;
      out_item.processed_tasks <= r_proc;
      out_item.last <= last_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.exec && item.mode == MODE_CLEAR)) begin
      for (int i = 0; i < PORTS; i++) begin
        recv_cnt[i] <= '0;
        proc_cnt[i] <= '0;
        succ_cnt[i] <= '0;
        byte_tot[i] <= '0;
        max_lat[i] <= '0;
        min_lat[i] <= MAX32;
      end
      active <= '0;
      elapsed <= '0;
    end else if (cmd.exec) begin
      if (item.mode == MODE_TICK) begin
        if (elapsed != MAX40) elapsed <= elapsed + 40'd1;
      end else if (port_ok) begin
        unique case (item.mode)
          MODE_RECV: begin
            if (recv_cnt[addr] != MAX32) recv_cnt[addr] <= recv_cnt[addr] + 32'd1;
            active[addr] <= 1'b1;
          end
          MODE_PROC: begin
            if (r_proc != MAX32) proc_cnt[addr] <= r_proc + 32'd1;
            if (item.success && succ_cnt[addr] != MAX32) begin
              succ_cnt[addr] <= succ_cnt[addr] + 32'd1;
            end
          end
          MODE_BYTES: begin
            byte_tot[addr] <= byte_sum[48] ? MAX48 : byte_sum[47:0];
          end
          MODE_LAT: begin
            if (item.latency_ms > r_max) max_lat[addr] <= item.latency_ms;
            if (item.latency_ms < min_lat[addr]) min_lat[addr] <= item.latency_ms;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/per_port_perf_monitor_top.sv =====
// Per-port performance monitor. Event items (received, processed, bytes,
// latency) are captured and then applied to the addressed port; tick and
// clear items take the same path. A check item walks all ports and, for
// each active port, runs a one-bit-per-cycle divider for the throughput,
// and the walk waits while the output register still holds an untaken
// result. Configuration writes are always ready.
`default_nettype none
module per_port_perf_monitor_top
  import ppm_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  wire         out_stall,
  output out_item_t   out_item,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [31:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ppm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
